// ===== design/otc_pkg.sv =====
// Shared constants, types and a helper function for the overcurrent trip block.
package otc_pkg;

	// Burst length and field widths
	localparam int SAMPLES = 8;
	localparam int ADC_W   = 12;
	localparam int CUR_W   = 12;
	localparam int TIME_W  = 32;
	localparam int MS_W    = 16;
	localparam int MODE_W  = 2;
	localparam int SUM_W   = $clog2(SAMPLES * (2 ** ADC_W));
	localparam int CNT_W   = $clog2(SAMPLES + 1);

	// Item kinds
	localparam logic [MODE_W-1:0] MODE_RUN    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POLL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd2;

	// Register map: word index = paddr[ADDR_W-1:2]
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int REG_W  = ADDR_W - 2;
	localparam logic [REG_W-1:0] REG_DRIVE_ENABLE  = 2'd0;
	localparam logic [REG_W-1:0] REG_COOLDOWN_MS   = 2'd1;
	localparam logic [REG_W-1:0] REG_READ_INTERVAL = 2'd2;
	localparam logic [REG_W-1:0] REG_CURRENT_LIMIT = 2'd3;

	// Register reset values
	localparam logic             RST_DRIVE_ENABLE  = 1'b1;
	localparam logic [MS_W-1:0]  RST_COOLDOWN_MS   = 16'd1000;
	localparam logic [MS_W-1:0]  RST_READ_INTERVAL = 16'd10;
	localparam logic [CUR_W-1:0] RST_CURRENT_LIMIT = 12'd1500;

	// avg * 5371 / 10000, truncated, as (avg * SCALE_MUL) >> SCALE_SHIFT.
	// SCALE_MUL = ceil(0.5371 * 2^24); the excess stays below one count
	// in 10000 for any 12-bit average, so the floor is exact.
	localparam int SCALE_SHIFT = 24;
	localparam int SCALE_MW    = 24;
	localparam logic [SCALE_MW-1:0] SCALE_MUL = 24'd9011043;

	typedef struct packed {
		logic             drive_enable;
		logic [MS_W-1:0]  cooldown_ms;
		logic [MS_W-1:0]  read_interval_ms;
		logic [CUR_W-1:0] current_limit_ma;
	} cfg_t;

	// Averaged reading to milliamps
	function automatic logic [CUR_W-1:0] scale_ma(input logic [ADC_W-1:0] avg);
		logic [ADC_W+SCALE_MW-1:0] prod;
		prod = {{SCALE_MW{1'b0}}, avg} * {{ADC_W{1'b0}}, SCALE_MUL};
		return prod[SCALE_SHIFT +: CUR_W];
	endfunction

endpackage

// ===== design/otc_regs.sv =====
// APB register file holding the trip configuration.
module otc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [otc_pkg::ADDR_W-1:0]  paddr,
	input  logic [otc_pkg::DATA_W-1:0]  pwdata,
	output logic [otc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output otc_pkg::cfg_t               cfg
);

	otc_pkg::cfg_t              cfg_q;
	logic                       wr_en;
	logic [otc_pkg::REG_W-1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[otc_pkg::ADDR_W-1:2];
	assign cfg     = cfg_q;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_enable     <= otc_pkg::RST_DRIVE_ENABLE;
			cfg_q.cooldown_ms      <= otc_pkg::RST_COOLDOWN_MS;
			cfg_q.read_interval_ms <= otc_pkg::RST_READ_INTERVAL;
			cfg_q.current_limit_ma <= otc_pkg::RST_CURRENT_LIMIT;
		end else if (wr_en) begin
			case (reg_idx)
				otc_pkg::REG_DRIVE_ENABLE: begin
					cfg_q.drive_enable <= pwdata[0];
				end
				otc_pkg::REG_COOLDOWN_MS: begin
					cfg_q.cooldown_ms <= pwdata[otc_pkg::MS_W-1:0];
				end
				otc_pkg::REG_READ_INTERVAL: begin
					cfg_q.read_interval_ms <= pwdata[otc_pkg::MS_W-1:0];
				end
				otc_pkg::REG_CURRENT_LIMIT: begin
					cfg_q.current_limit_ma <= pwdata[otc_pkg::CUR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read mux, zero extended
	always_comb begin
		case (reg_idx)
			otc_pkg::REG_DRIVE_ENABLE: begin
				prdata = {{(otc_pkg::DATA_W-1){1'b0}}, cfg_q.drive_enable};
			end
			otc_pkg::REG_COOLDOWN_MS: begin
				prdata = {{(otc_pkg::DATA_W-otc_pkg::MS_W){1'b0}}, cfg_q.cooldown_ms};
			end
			otc_pkg::REG_READ_INTERVAL: begin
				prdata = {{(otc_pkg::DATA_W-otc_pkg::MS_W){1'b0}}, cfg_q.read_interval_ms};
			end
			otc_pkg::REG_CURRENT_LIMIT: begin
				prdata = {{(otc_pkg::DATA_W-otc_pkg::CUR_W){1'b0}}, cfg_q.current_limit_ma};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

// ===== design/overcurrent_trip_cooldown.sv =====
// Overcurrent trip with cooldown: input register, single-pass update, result register.
// Each input transaction (run command, millisecond poll or ADC sample) produces exactly
// one result transaction reporting drive level, cooldown status, the last averaged
// current in mA, whether a burst is waiting for samples, and whether this item closed a
// burst. Items are taken into an input register and resolved combinationally against
// the block state, then held in an output register; the block sustains one
// transaction per cycle as long as results are taken. A stalled result register stops
// the update stage, which in turn holds in_ready low once the input register is also
// full. A burst averages 8 samples and scales the average by 0.5371 to mA; a trip
// starts cooldown timed from the poll that opened the burst. Configuration registers
// (APB, word addresses 0x0 enable, 0x4 cooldown ms, 0x8 read interval ms, 0xC current
// limit mA) should only be written while idle.
module overcurrent_trip_cooldown (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [otc_pkg::ADDR_W-1:0]  paddr,
	input  logic [otc_pkg::DATA_W-1:0]  pwdata,
	output logic [otc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [otc_pkg::MODE_W-1:0]  mode,
	input  logic                        run_request,
	input  logic                        override,
	input  logic [otc_pkg::TIME_W-1:0]  now_ms,
	input  logic [otc_pkg::ADC_W-1:0]   adc_sample,
	// output channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        drive_out,
	output logic                        cooling_down,
	output logic [otc_pkg::CUR_W-1:0]   current_ma,
	output logic                        sample_request,
	output logic                        measure_done
);

	otc_pkg::cfg_t cfg;

	otc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register
	logic                        valid_s1;
	logic [otc_pkg::MODE_W-1:0]  mode_s1;
	logic                        run_s1;
	logic                        ovr_s1;
	logic [otc_pkg::TIME_W-1:0]  now_s1;
	logic [otc_pkg::ADC_W-1:0]   adc_s1;

	// Block state
	logic                        drive_q;
	logic                        cool_q;
	logic [otc_pkg::TIME_W-1:0]  cool_start_q;
	logic [otc_pkg::TIME_W-1:0]  last_read_q;
	logic                        burst_q;
	logic [otc_pkg::CNT_W-1:0]   cnt_q;
	logic [otc_pkg::SUM_W-1:0]   sum_q;
	logic [otc_pkg::CUR_W-1:0]   cur_q;

	// Next state
	logic                        drive_n;
	logic                        cool_n;
	logic [otc_pkg::TIME_W-1:0]  cool_start_n;
	logic [otc_pkg::TIME_W-1:0]  last_read_n;
	logic                        burst_n;
	logic [otc_pkg::CNT_W-1:0]   cnt_n;
	logic [otc_pkg::SUM_W-1:0]   sum_n;
	logic [otc_pkg::CUR_W-1:0]   cur_n;
	logic                        done_n;

	// Update helpers
	logic [otc_pkg::TIME_W-1:0]  cool_age;
	logic [otc_pkg::TIME_W-1:0]  read_age;
	logic                        cool_elapsed;
	logic                        read_due;
	logic [otc_pkg::SUM_W-1:0]   sum_add;
	logic [otc_pkg::CNT_W-1:0]   cnt_add;
	logic [otc_pkg::ADC_W-1:0]   avg;
	logic [otc_pkg::CUR_W-1:0]   cur_calc;

	// Result register
	logic                        out_valid_q;
	logic                        drive_out_q;
	logic                        cool_out_q;
	logic [otc_pkg::CUR_W-1:0]   cur_out_q;
	logic                        req_out_q;
	logic                        done_out_q;

	logic                        adv;

	// Handshake: update stage moves when the result register is free or draining
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			run_s1  <= run_request;
			ovr_s1  <= override;
			now_s1  <= now_ms;
			adc_s1  <= adc_sample;
		end
	end

	// Shared arithmetic for polls and samples
	assign cool_age     = now_s1 - cool_start_q;
	assign read_age     = now_s1 - last_read_q;
	assign cool_elapsed = cool_age >= {{(otc_pkg::TIME_W-otc_pkg::MS_W){1'b0}}, cfg.cooldown_ms};
	assign read_due     = read_age >=
		{{(otc_pkg::TIME_W-otc_pkg::MS_W){1'b0}}, cfg.read_interval_ms};
	assign sum_add      = sum_q + {{(otc_pkg::SUM_W-otc_pkg::ADC_W){1'b0}}, adc_s1};
	assign cnt_add      = cnt_q + otc_pkg::CNT_W'(1);
	assign avg          = otc_pkg::ADC_W'(sum_add / otc_pkg::SAMPLES);
	assign cur_calc     = otc_pkg::scale_ma(avg);

	// Single-pass state update for the item in the input register
	always_comb begin
		drive_n      = drive_q;
		cool_n       = cool_q;
		cool_start_n = cool_start_q;
		last_read_n  = last_read_q;
		burst_n      = burst_q;
		cnt_n        = cnt_q;
		sum_n        = sum_q;
		cur_n        = cur_q;
		done_n       = 1'b0;
		case (mode_s1)
			otc_pkg::MODE_RUN: begin
				if (!cfg.drive_enable) begin
					drive_n = 1'b0;
				end else if (!cool_q || ovr_s1) begin
					drive_n = run_s1;
				end
			end
			otc_pkg::MODE_POLL: begin
				// still cooling: poll does nothing
				if (!cool_q || cool_elapsed) begin
					cool_n = 1'b0;
					if (read_due) begin
						last_read_n = now_s1;
						burst_n     = 1'b1;
						cnt_n       = '0;
						sum_n       = '0;
					end
				end
			end
			otc_pkg::MODE_SAMPLE: begin
				if (burst_q) begin
					if (cnt_add == otc_pkg::CNT_W'(otc_pkg::SAMPLES)) begin
						done_n  = 1'b1;
						cur_n   = cur_calc;
						burst_n = 1'b0;
						cnt_n   = '0;
						sum_n   = '0;
						if (cur_calc > cfg.current_limit_ma) begin
							// trip: forced off unless enabled and already cooling
							drive_n      = (cfg.drive_enable && cool_q) ? drive_q : 1'b0;
							cool_n       = 1'b1;
							cool_start_n = last_read_q;
						end
					end else begin
						cnt_n = cnt_add;
						sum_n = sum_add;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// State commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q      <= 1'b0;
			cool_q       <= 1'b0;
			cool_start_q <= '0;
			last_read_q  <= '0;
			burst_q      <= 1'b0;
			cnt_q        <= '0;
			sum_q        <= '0;
			cur_q        <= '0;
		end else if (adv) begin
			drive_q      <= drive_n;
			cool_q       <= cool_n;
			cool_start_q <= cool_start_n;
			last_read_q  <= last_read_n;
			burst_q      <= burst_n;
			cnt_q        <= cnt_n;
			sum_q        <= sum_n;
			cur_q        <= cur_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_out_q <= drive_n;
			cool_out_q  <= cool_n;
			cur_out_q   <= cur_n;
			req_out_q   <= burst_n;
			done_out_q  <= done_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_out      = drive_out_q;
	assign cooling_down   = cool_out_q;
	assign current_ma     = cur_out_q;
	assign sample_request = req_out_q;
	assign measure_done   = done_out_q;

	// Checks
	a_done_closes_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && measure_done |-> !sample_request)
		else $error("completed burst still reports a pending request");

	a_trip_drops_drive: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cool_q) |-> !drive_q)
		else $error("cooldown started with drive still on");

	a_burst_from_poll: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(burst_q) |-> $past(adv && mode_s1 == otc_pkg::MODE_POLL))
		else $error("burst opened by something other than a poll");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cool_q) && $stable(drive_q) && $stable(burst_q))
		else $error("state changed without an item advancing");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < otc_pkg::CNT_W'(otc_pkg::SAMPLES))
		else $error("sample count out of range");

endmodule
